>>> design/jkar_pkg.sv
// package for the jittered key auto-repeater
// holds the command codes, timing constants, item types and the hold jitter function
// no dependencies

package jkar_pkg;

	typedef enum logic [3:0] {
		CMD_TICK      = 4'd0,
		CMD_START     = 4'd1,
		CMD_STOP      = 4'd2,
		CMD_RESET     = 4'd3,
		CMD_SET_IVL   = 4'd4,
		CMD_IVL_UP    = 4'd5,
		CMD_IVL_DOWN  = 4'd6,
		CMD_COUNT_UP  = 4'd7,
		CMD_COUNT_DN  = 4'd8
	} cmd_t;

	localparam logic [6:0]  HoldBase      = 7'd85;
	localparam logic [7:0]  HoldSpan      = 8'd40;
	localparam logic [7:0]  HoldRecip     = 8'd205;   // 8192 / 40, rounded up
	localparam int          HoldShift     = 13;
	localparam logic [32:0] GapBase       = 33'd75;
	localparam logic [31:0] IntervalMin   = 32'd500;
	localparam logic [6:0]  ReleaseWait   = 7'd20;
	localparam logic [31:0] IntervalReset = 32'd1000;

	typedef struct packed {
		logic [7:0]  random_gap;
		logic [7:0]  random_hold;
		logic [31:0] amount;
		logic [3:0]  command;
	} in_item_t;

	typedef struct packed {
		logic       fire;
		logic [6:0] hold;
	} tap_t;

	// 85 + rnd mod 40, the quotient by reciprocal is exact for 8-bit inputs
	function automatic logic [6:0] hold_jitter(input logic [7:0] rnd);
		logic [15:0] prod;
		logic [2:0]  quot;
		logic [7:0]  rem;
		prod = rnd * HoldRecip;
		quot = prod[15:HoldShift];
		rem  = rnd - 8'(quot * HoldSpan);
		return HoldBase + rem[6:0];
	endfunction

endpackage

>>> design/jittered_key_auto_repeater_top.sv
// top level of the jittered key auto-repeater: input register, control, result queue
// an accepted item is registered in the input register, then updates the state and queues its tap
// once the queue has a slot; a press is offered once its tap is queued, and its release right after it
// throughput: one item per cycle while firing items find a slot; a firing item puts two results on
// the single output port, so a run of firing items is limited to one per two results taken
// reset: asynchronous, active low; interval 1000, no taps, idle, queue empty
// depends on jkar_pkg, jkar_ctrl, jkar_out

module jittered_key_auto_repeater_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // command [3:0], amount [35:4], random_hold [43:36],
	                               // random_gap [51:44], zero [55:52]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // key_down [0], wait_ms [7:1]
	output logic        m_tlast
);

	jkar_pkg::in_item_t item_s1;
	logic               valid_s1;
	jkar_pkg::tap_t     tap;
	logic               room;
	logic               advance;

	// an item that fires waits in the input register until the queue has a slot
	assign advance  = valid_s1 && (!tap.fire || room);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			item_s1 <= s_tdata[51:0];
	end

	jkar_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.take   (advance),
		.tap    (tap)
	);

	jkar_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (advance && tap.fire),
		.tap      (tap),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

>>> design/jkar_ctrl.sv
// settings and tap timing state of the jittered key auto-repeater
// updates the state for one item per cycle while take is high and flags a tap with its hold time
// depends on jkar_pkg

module jkar_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  jkar_pkg::in_item_t  item,
	input  logic                take,
	output jkar_pkg::tap_t      tap
);

	logic [31:0] interval_q;
	logic [15:0] total_q;
	logic [15:0] index_q;
	logic        running_q;
	logic [32:0] ticks_q;

	logic [31:0] interval_d;
	logic [15:0] total_d;
	logic [15:0] index_d;
	logic        running_d;
	logic [32:0] ticks_d;

	logic        fire;
	logic [15:0] base_index;
	logic [16:0] next_index;
	logic [32:0] ivl_sum;
	logic [31:0] ivl_diff;
	logic [32:0] cnt_sum;
	logic [32:0] gap_ticks;

	assign ivl_sum    = {1'b0, interval_q} + {1'b0, item.amount};
	assign ivl_diff   = interval_q - item.amount;
	assign cnt_sum    = {17'd0, total_q} + {1'b0, item.amount};
	assign gap_ticks  = {1'b0, interval_q} + jkar_pkg::GapBase + 33'(item.random_gap[5:0]);

	always_comb begin
		fire = 1'b0;
		if (jkar_pkg::cmd_t'(item.command) == jkar_pkg::CMD_TICK)
			fire = running_q && (ticks_q <= 33'd1);
		else if (jkar_pkg::cmd_t'(item.command) == jkar_pkg::CMD_START)
			fire = !running_q && (total_q > 16'd1);
	end

	// start fires its first tap with the index already at one
	assign base_index = running_q ? index_q : 16'd1;
	assign next_index = {1'b0, base_index} + 17'd1;

	always_comb begin
		interval_d = interval_q;
		total_d    = total_q;
		index_d    = index_q;
		running_d  = running_q;
		ticks_d    = ticks_q;
		if (fire) begin
			if (next_index <= {1'b0, total_q}) begin
				running_d = 1'b1;
				index_d   = next_index[15:0];
				ticks_d   = gap_ticks;
			end else begin
				running_d  = 1'b0;
				ticks_d    = '0;
				interval_d = '0;
				total_d    = '0;
				index_d    = '0;
			end
		end else if (jkar_pkg::cmd_t'(item.command) == jkar_pkg::CMD_TICK) begin
			if (running_q)
				ticks_d = ticks_q - 33'd1;
		end else if (jkar_pkg::cmd_t'(item.command) == jkar_pkg::CMD_STOP) begin
			if (running_q) begin
				running_d  = 1'b0;
				ticks_d    = '0;
				interval_d = '0;
				total_d    = '0;
				index_d    = '0;
			end
		end else if (!running_q) begin
			unique case (jkar_pkg::cmd_t'(item.command))
				jkar_pkg::CMD_RESET: begin
					interval_d = '0;
					total_d    = '0;
					index_d    = '0;
				end
				jkar_pkg::CMD_SET_IVL: interval_d = item.amount;
				jkar_pkg::CMD_IVL_UP: begin
					if (!ivl_sum[32] && ivl_sum[31:0] >= jkar_pkg::IntervalMin)
						interval_d = ivl_sum[31:0];
				end
				jkar_pkg::CMD_IVL_DOWN: begin
					if (item.amount <= interval_q && ivl_diff >= jkar_pkg::IntervalMin)
						interval_d = ivl_diff;
				end
				jkar_pkg::CMD_COUNT_UP: begin
					if (cnt_sum <= 33'hFFFF && cnt_sum != 33'd0)
						total_d = cnt_sum[15:0];
				end
				jkar_pkg::CMD_COUNT_DN: begin
					if (item.amount < {16'd0, total_q})
						total_d = total_q - item.amount[15:0];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= jkar_pkg::IntervalReset;
			total_q    <= '0;
			index_q    <= '0;
			running_q  <= 1'b0;
			ticks_q    <= '0;
		end else if (take) begin
			interval_q <= interval_d;
			total_q    <= total_d;
			index_q    <= index_d;
			running_q  <= running_d;
			ticks_q    <= ticks_d;
		end
	end

	assign tap.fire = fire;
	assign tap.hold = jkar_pkg::hold_jitter(item.random_hold);

	// idle means no tap in progress
	a_idle_index: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> index_q == 16'd0)
		else $error("tap index not cleared while idle");

	a_run_index: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> (index_q >= 16'd1 && index_q <= total_q))
		else $error("tap index outside run");

	a_run_total: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> total_q > 16'd1)
		else $error("running with tap count of one or less");

endmodule

>>> design/jkar_out.sv
// result queue of the jittered key auto-repeater
// two tap slots, each played out as a press item then a release item
// depends on jkar_pkg

module jkar_out (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  jkar_pkg::tap_t  tap,
	output logic            room,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [7:0]      m_tdata,   // key_down [0], wait_ms [7:1]
	output logic            m_tlast
);

	logic [6:0] hold_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       phase_q;   // 0 press next, 1 release next
	logic       pop;
	logic       pop_tap;

	assign room     = cnt_q != 2'd2;
	assign m_tvalid = cnt_q != 2'd0;
	assign pop      = m_tvalid && m_tready;
	assign pop_tap  = pop && phase_q;

	assign m_tdata = {(phase_q ? jkar_pkg::ReleaseWait : hold_q[rd_q]), !phase_q};
	assign m_tlast = phase_q;

	always_ff @(posedge clk) begin
		if (push)
			hold_q[wr_q] <= tap.hold;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			cnt_q   <= '0;
			phase_q <= 1'b0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop) begin
				phase_q <= !phase_q;
				if (phase_q)
					rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop_tap);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2)
		else $error("result queue overfilled");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room)
		else $error("tap pushed into full queue");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !phase_q) |=> (m_tvalid && phase_q))
		else $error("press not followed by its release");

endmodule

>>> verif/jkar_checker.sv
`timescale 1ns / 100ps
// checker for the jittered key auto-repeater: predicts the press and release items of each tap
// from the accepted input items and compares them with the output stream
// depends on jkar_pkg

module jkar_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,   // command [3:0], amount [35:4], random_hold [43:36],
	                               // random_gap [51:44], zero [55:52]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // key_down [0], wait_ms [7:1]
	input  logic        m_tlast,
	output int          fail_count,
	output int          outstanding
);

	localparam int GapSpan = 64;

	typedef struct packed {
		logic       key_down;
		logic [6:0] wait_ms;
		logic       last;
	} key_event_t;

	key_event_t  due_events[$];

	logic [31:0] interval_ms;
	logic [15:0] tap_total;
	logic [15:0] tap_index;
	logic        running;
	logic [32:0] ticks_left;

	// press then release; the index is compared before it moves, so a full count never wraps
	task automatic fire_tap(input logic [7:0] hold_rnd, input logic [7:0] gap_rnd);
		key_event_t press_ev;
		key_event_t lift_ev;
		press_ev.key_down = 1'b1;
		press_ev.wait_ms = 7'(jkar_pkg::HoldBase + hold_rnd % jkar_pkg::HoldSpan);
		press_ev.last = 1'b0;
		lift_ev.key_down = 1'b0;
		lift_ev.wait_ms = jkar_pkg::ReleaseWait;
		lift_ev.last = 1'b1;
		due_events.push_back(press_ev);
		due_events.push_back(lift_ev);
		if (tap_index < tap_total) begin
			tap_index = tap_index + 16'd1;
			ticks_left = {1'b0, interval_ms} + jkar_pkg::GapBase + 33'(gap_rnd % GapSpan);
		end else begin
			running = 1'b0;
			ticks_left = '0;
			interval_ms = '0;
			tap_total = '0;
			tap_index = '0;
		end
	endtask

	task automatic apply_command(input jkar_pkg::in_item_t item);
		logic [32:0] wide;
		case (item.command)
		jkar_pkg::CMD_TICK: begin
			if (running) begin
				if (ticks_left > 33'd1) begin
					ticks_left = ticks_left - 33'd1;
				end else begin
					ticks_left = '0;
					fire_tap(item.random_hold, item.random_gap);
				end
			end
		end
		jkar_pkg::CMD_START: begin
			if (!running && tap_total > 16'd1) begin
				tap_index = 16'd1;
				running = 1'b1;
				fire_tap(item.random_hold, item.random_gap);
			end
		end
		jkar_pkg::CMD_STOP: begin
			if (running) begin
				running = 1'b0;
				ticks_left = '0;
				interval_ms = '0;
				tap_total = '0;
				tap_index = '0;
			end
		end
		default: begin
			// settings only move while idle
			if (!running) begin
				case (item.command)
				jkar_pkg::CMD_RESET: begin
					interval_ms = '0;
					tap_total = '0;
					tap_index = '0;
				end
				jkar_pkg::CMD_SET_IVL: interval_ms = item.amount;
				jkar_pkg::CMD_IVL_UP: begin
					wide = {1'b0, interval_ms} + {1'b0, item.amount};
					if (!wide[32] && wide[31:0] >= jkar_pkg::IntervalMin)
						interval_ms = wide[31:0];
				end
				jkar_pkg::CMD_IVL_DOWN: begin
					if (item.amount <= interval_ms
							&& interval_ms - item.amount >= jkar_pkg::IntervalMin)
						interval_ms = interval_ms - item.amount;
				end
				jkar_pkg::CMD_COUNT_UP: begin
					wide = {17'b0, tap_total} + {1'b0, item.amount};
					if (wide <= 33'h0_FFFF && wide != '0)
						tap_total = wide[15:0];
				end
				jkar_pkg::CMD_COUNT_DN: begin
					if (item.amount < {16'b0, tap_total})
						tap_total = tap_total - item.amount[15:0];
				end
				default: ;
				endcase
			end
		end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		key_event_t want;
		if (!arst_n) begin
			interval_ms = jkar_pkg::IntervalReset;
			tap_total = '0;
			tap_index = '0;
			running = 1'b0;
			ticks_left = '0;
			due_events.delete();
			outstanding = 0;
			fail_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_events.size() == 0) begin
					$error("result with none due: key_down %0b wait_ms %0d last %0b",
						m_tdata[0], m_tdata[7:1], m_tlast);
					fail_count++;
				end else begin
					want = due_events.pop_front();
					if (m_tdata[0] !== want.key_down) begin
						$error("key_down: expected %0b, got %0b", want.key_down, m_tdata[0]);
						fail_count++;
					end
					if (m_tdata[7:1] !== want.wait_ms) begin
						$error("wait_ms: expected %0d, got %0d", want.wait_ms, m_tdata[7:1]);
						fail_count++;
					end
					if (m_tlast !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, m_tlast);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				apply_command(s_tdata[51:0]);
			outstanding = due_events.size();
		end
	end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// testbench top for the jittered key auto-repeater: clock, reset, item stimulus,
// output back-pressure and the verdict; checking lives in jkar_checker
// depends on jkar_pkg, jkar_checker and jittered_key_auto_repeater_top

module tb_top;

	localparam int          CycleLimit   = 400000;
	localparam int          ItemsWanted  = 1450;
	localparam int          TapsWanted   = 12;
	localparam int          LongHold     = 400;
	localparam int          DrainCycles  = 12;
	localparam int          JitterSpan   = 64;
	localparam logic [3:0]  CmdTopUnused = 4'hF;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_COMB, RX_TRICKLE} rx_mode_e;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;   // command [3:0], amount [35:4], random_hold [43:36],
	                        // random_gap [51:44], zero [55:52]
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // key_down [0], wait_ms [7:1]
	logic        m_tlast;
	int          fail_count;
	int          outstanding;

	int unsigned burst_left = 0;
	int unsigned items_sent = 0;
	bit          hold_req = 1'b0;
	bit          hold_done = 1'b0;
	int unsigned hold_left = 0;
	rx_mode_e    rx_mode = RX_OPEN;
	int unsigned rx_left = 0;
	int unsigned rx_phase = 0;

	jittered_key_auto_repeater_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	jkar_checker i_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// called just after a rising edge; returns just after the edge that took the item
	task automatic push_item(input logic [3:0] cmd, input logic [31:0] amt,
			input logic [7:0] hold_rnd, input logic [7:0] gap_rnd);
		int unsigned idle;
		if (burst_left == 0) begin
			idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (idle != 0) begin
				s_tvalid <= 1'b0;
				repeat (idle) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
			                                        : $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, gap_rnd, hold_rnd, amt, cmd};
		do @(posedge clk); while (!s_tready);
		burst_left--;
		items_sent++;
	endtask

	// receiver: changing stall patterns, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = LongHold - 1;
			m_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_e'($urandom_range(0, 3));
				rx_left = $urandom_range(16, 160);
			end
			rx_left--;
			rx_phase++;
			case (rx_mode)
			RX_OPEN:  m_tready <= 1'b1;
			RX_COIN:  m_tready <= 1'($urandom);
			RX_COMB:  m_tready <= (rx_phase % 5) < 3;
			default:  m_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int unsigned taps_fired;
		int unsigned ivl;
		int unsigned taps;
		int unsigned fired;
		int unsigned ticks_due;
		int unsigned pick;
		logic [31:0] amt;
		logic [7:0]  gap_seed;
		logic [3:0]  cmd;
		bit          aborted;

		taps_fired = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle no-ops, rejected edges of interval and count, widest gap
		push_item(jkar_pkg::CMD_TICK, $urandom, 8'h00, 8'h00);
		push_item(jkar_pkg::CMD_STOP, $urandom, 8'hFF, 8'hFF);
		push_item(jkar_pkg::CMD_START, '0, 8'h00, 8'h00);
		push_item(jkar_pkg::CMD_COUNT_DN, 32'd1, 8'h55, 8'hAA);
		push_item(jkar_pkg::CMD_COUNT_UP, 32'd0, 8'hAA, 8'h55);
		push_item(jkar_pkg::CMD_COUNT_UP, 32'd1, 8'h00, 8'h00);
		push_item(jkar_pkg::CMD_START, '1, 8'h27, 8'h3F);
		push_item(jkar_pkg::CMD_COUNT_DN, 32'd1, 8'h00, 8'h00);
		push_item(jkar_pkg::CMD_IVL_DOWN, 32'd501, 8'h00, 8'h00);
		push_item(jkar_pkg::CMD_IVL_DOWN, '1, 8'h00, 8'h00);
		push_item(jkar_pkg::CMD_IVL_DOWN, 32'd500, 8'h00, 8'h00);
		push_item(jkar_pkg::CMD_IVL_UP, '1, 8'h00, 8'h00);
		push_item(jkar_pkg::CMD_SET_IVL, '1, 8'h00, 8'h00);
		push_item(jkar_pkg::CMD_IVL_UP, 32'd0, 8'h00, 8'h00);
		push_item(jkar_pkg::CMD_COUNT_UP, 32'd65534, 8'h00, 8'h00);
		push_item(jkar_pkg::CMD_COUNT_UP, 32'd1, 8'h00, 8'h00);
		push_item(jkar_pkg::CMD_COUNT_DN, 32'd65535, 8'h00, 8'h00);
		push_item(CmdTopUnused, '1, 8'hFF, 8'hFF);
		push_item(jkar_pkg::CMD_START, 32'h5555_AAAA, 8'hFF, 8'hFF);
		push_item(jkar_pkg::CMD_TICK, 32'hAAAA_5555, 8'h00, 8'h00);
		push_item(jkar_pkg::CMD_COUNT_UP, 32'd3, 8'h28, 8'h40);
		push_item(jkar_pkg::CMD_RESET, '0, 8'h00, 8'h00);
		push_item(jkar_pkg::CMD_START, '0, 8'h00, 8'h00);
		push_item(jkar_pkg::CMD_STOP, '0, 8'h00, 8'h00);
		push_item(jkar_pkg::CMD_RESET, '1, 8'h00, 8'h00);

		// back-to-back taps against a stalled receiver so the block fills and stalls its input
		hold_req = 1'b1;
		repeat (24) begin
			push_item(jkar_pkg::CMD_COUNT_UP, 32'd2, 8'($urandom), 8'($urandom));
			push_item(jkar_pkg::CMD_START, $urandom, 8'($urandom), 8'($urandom));
			push_item(jkar_pkg::CMD_STOP, $urandom, 8'($urandom), 8'($urandom));
		end

		while (items_sent < ItemsWanted || taps_fired < TapsWanted) begin
			// settings churn: mostly bounded or rejected changes, any command
			repeat ($urandom_range(1, 6)) begin
				case ($urandom_range(0, 4))
				0:       amt = $urandom;
				1:       amt = $urandom_range(0, 3);
				2:       amt = $urandom_range(400, 1200);
				3:       amt = 32'hFFFF_FFFF - $urandom_range(0, 1500);
				default: amt = $urandom_range(65530, 65540);
				endcase
				push_item(4'($urandom), amt, 8'($urandom), 8'($urandom));
			end

			// a well-formed run of taps with random jitter
			ivl = ($urandom_range(0, 9) == 0) ? $urandom_range(500, 700) : $urandom_range(0, 24);
			taps = $urandom_range(2, 4);
			gap_seed = 8'($urandom);
			push_item(jkar_pkg::CMD_STOP, $urandom, 8'($urandom), 8'($urandom));
			push_item(jkar_pkg::CMD_RESET, $urandom, 8'($urandom), 8'($urandom));
			push_item(jkar_pkg::CMD_SET_IVL, ivl, 8'($urandom), 8'($urandom));
			push_item(jkar_pkg::CMD_COUNT_UP, taps, 8'($urandom), 8'($urandom));
			push_item(jkar_pkg::CMD_START, $urandom, 8'($urandom), gap_seed);
			fired = 1;
			taps_fired++;
			ticks_due = ivl + 32'(jkar_pkg::GapBase) + gap_seed % JitterSpan;
			aborted = 1'b0;
			while (fired < taps && !aborted) begin
				pick = $urandom_range(0, 999);
				// stop now and then, and always once the item budget is spent
				if (pick == 0 || items_sent >= ItemsWanted) begin
					push_item(jkar_pkg::CMD_STOP, $urandom, 8'($urandom), 8'($urandom));
					aborted = 1'b1;
				end else if (pick < 60) begin
					// anything but tick or stop leaves a running block alone
					do cmd = 4'($urandom);
					while (cmd == jkar_pkg::CMD_TICK || cmd == jkar_pkg::CMD_STOP);
					push_item(cmd, $urandom, 8'($urandom), 8'($urandom));
				end else begin
					gap_seed = 8'($urandom);
					push_item(jkar_pkg::CMD_TICK, $urandom, 8'($urandom), gap_seed);
					ticks_due--;
					if (ticks_due == 0) begin
						fired++;
						taps_fired++;
						ticks_due = ivl + 32'(jkar_pkg::GapBase) + gap_seed % JitterSpan;
					end
				end
			end
		end

		s_tvalid <= 1'b0;
		wait (outstanding == 0);
		repeat (DrainCycles) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> jittered_key_auto_repeater_top.f
design/jkar_pkg.sv
design/jkar_ctrl.sv
design/jkar_out.sv
design/jittered_key_auto_repeater_top.sv
verif/jkar_checker.sv
verif/tb_top.sv
